### sv/tmva_pkg.sv
package tmva_pkg;

  // Activation store geometry
  localparam int unsigned MAX_VECTOR_LEN = 2048;
  localparam int unsigned CODES_PER_WORD = 16;
  localparam int unsigned LANE_W = $clog2(CODES_PER_WORD);
  localparam int unsigned WORD_CAP = MAX_VECTOR_LEN / CODES_PER_WORD;
  localparam int unsigned ROW_W = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
  localparam int unsigned POS_W = $clog2(WORD_CAP + 1);

  // Field widths
  localparam int unsigned ACT_IDX_W = 11;
  localparam int unsigned ACT_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CODE_W = 2;
  localparam int unsigned SUM_W = 20;

  // Arithmetic widths: one product is at most twice an activation in magnitude.
  localparam int unsigned PROD_W = ACT_W + 2;
  localparam int unsigned DOT_W = PROD_W + LANE_W;
  localparam int unsigned ACC_W = $clog2(MAX_VECTOR_LEN) + ACT_W + 2;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Result queue at the output of the back end; the depth is a power of two.
  localparam int unsigned RESQ_DEPTH = 2;
  localparam int unsigned RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int unsigned RESQ_CNT_W = RESQ_PTR_W + 1;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_WEIGHT = 1'b1
  } kind_e;

  typedef enum logic [CODE_W-1:0] {
    CODE_NEG  = 2'b00,
    CODE_ZERO = 2'b01,
    CODE_POS  = 2'b10,
    CODE_TWO  = 2'b11
  } code_e;

  typedef struct packed {
    kind_e                    kind;
    logic                     wr_en;
    logic [ROW_W-1:0]         row;
    logic [LANE_W-1:0]        lane;
    logic signed [ACT_W-1:0]  value;
    logic [WORD_W-1:0]        word;
    logic                     skip;
    logic                     last;
    logic                     ovf;
  } cmd_t;

endpackage

### sv/ternary_matrix_vector_accumulate.sv
// Ternary-weight by int8-activation row accumulator. Requests are either
// activation loads or packed weight words of sixteen 2-bit codes; a word that
// ends a row yields one result, the saturated signed row sum and an overflow
// flag for rows longer than the activation store. One request is taken per
// cycle when the command queue (four deep) has room; each request makes one
// access to the single port of the activation store in the back end, which
// holds sixteen activations per row so that one read serves a whole word.
// A row-ending request is written into the command queue; when it leaves the
// queue, the store read and the word are registered, and the adder tree and
// accumulate then write its result into the output queue. The output queue
// is two deep, and a request leaves the command queue only while the output
// queue has room for one result beyond any still in the accumulate stage; so
// even with the output read every cycle, row-ending words that follow one
// another can stall in the command queue, and while the output queue is full
// and unread, requests back up into the command queue.
module ternary_matrix_vector_accumulate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                kind_i,
  input  logic [tmva_pkg::ACT_IDX_W-1:0]      act_index_i,
  input  logic signed [tmva_pkg::ACT_W-1:0]   act_value_i,
  input  logic [tmva_pkg::WORD_W-1:0]         weight_word_i,
  input  logic                                row_last_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [tmva_pkg::SUM_W-1:0]   row_sum_o,
  output logic                                row_overflow_o
);

  tmva_pkg::cmd_t front_cmd, back_cmd;
  logic           front_push;
  logic           q_full, q_empty, q_pop;

  tmva_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .q_full_i      (q_full),
    .kind_i        (kind_i),
    .act_index_i   (act_index_i),
    .act_value_i   (act_value_i),
    .weight_word_i (weight_word_i),
    .row_last_i    (row_last_i),
    .cmd_push_o    (front_push),
    .cmd_o         (front_cmd)
  );

  tmva_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (back_cmd),
    .empty_o (q_empty)
  );

  tmva_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .cmd_i          (back_cmd),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .row_sum_o      (row_sum_o),
    .row_overflow_o (row_overflow_o)
  );

  assign full = q_full;

endmodule

### sv/tmva_front.sv
module tmva_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic                                 q_full_i,
  input  logic                                 kind_i,
  input  logic [tmva_pkg::ACT_IDX_W-1:0]       act_index_i,
  input  logic signed [tmva_pkg::ACT_W-1:0]    act_value_i,
  input  logic [tmva_pkg::WORD_W-1:0]          weight_word_i,
  input  logic                                 row_last_i,
  output logic                                 cmd_push_o,
  output tmva_pkg::cmd_t                       cmd_o
);

  logic [tmva_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       ovf_q, ovf_d;
  logic                       accept;
  logic                       is_weight;
  logic                       skip;

  assign accept    = push_i & ~q_full_i;
  assign is_weight = (tmva_pkg::kind_e'(kind_i) == tmva_pkg::KIND_WEIGHT);
  // Once the row has used every store row, further words only raise the flag.
  assign skip      = (pos_q >= tmva_pkg::POS_W'(tmva_pkg::WORD_CAP));

  always_comb begin
    cmd_o.kind  = tmva_pkg::kind_e'(kind_i);
    cmd_o.wr_en = (32'(act_index_i) < tmva_pkg::MAX_VECTOR_LEN);
    if (is_weight) begin
      cmd_o.row = pos_q[tmva_pkg::ROW_W-1:0];
    end else begin
      cmd_o.row = tmva_pkg::ROW_W'(act_index_i >> tmva_pkg::LANE_W);
    end
    cmd_o.lane  = act_index_i[tmva_pkg::LANE_W-1:0];
    cmd_o.value = act_value_i;
    cmd_o.word  = weight_word_i;
    cmd_o.skip  = skip;
    cmd_o.last  = row_last_i;
    cmd_o.ovf   = ovf_q | skip;
  end

  assign cmd_push_o = accept;

  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (accept && is_weight) begin
      if (row_last_i) begin
        pos_d = '0;
        ovf_d = 1'b0;
      end else if (skip) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

### sv/tmva_cmd_queue.sv
module tmva_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tmva_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tmva_pkg::cmd_t data_o,
  output logic           empty_o
);

  tmva_pkg::cmd_t                  entry_q [tmva_pkg::CMDQ_DEPTH];
  logic [tmva_pkg::CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tmva_pkg::CMDQ_PTR_W:0]   cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == (tmva_pkg::CMDQ_PTR_W + 1)'(tmva_pkg::CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/tmva_back.sv
module tmva_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  tmva_pkg::cmd_t                     cmd_i,
  output logic                               q_pop_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic signed [tmva_pkg::SUM_W-1:0]  row_sum_o,
  output logic                               row_overflow_o
);

  localparam int unsigned CMP_W = (tmva_pkg::ACC_W > tmva_pkg::SUM_W + 1) ?
                                  tmva_pkg::ACC_W : tmva_pkg::SUM_W + 1;
  localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'((1 << (tmva_pkg::SUM_W - 1)) - 1);
  localparam logic signed [CMP_W-1:0] SAT_LO = -SAT_HI - CMP_W'(1);

  // Activation store: one row holds the sixteen activations of one weight word.
  logic [tmva_pkg::CODES_PER_WORD-1:0][tmva_pkg::ACT_W-1:0] mem_q [tmva_pkg::WORD_CAP];
  logic [tmva_pkg::CODES_PER_WORD-1:0][tmva_pkg::ACT_W-1:0] rd_q;

  logic                         issue, credit_ok;
  logic                         s2_valid_q;
  logic [tmva_pkg::WORD_W-1:0]  s2_word_q;
  logic                         s2_skip_q, s2_last_q, s2_ovf_q;

  logic signed [tmva_pkg::PROD_W-1:0] prod [tmva_pkg::CODES_PER_WORD];
  logic signed [tmva_pkg::DOT_W-1:0]  lvl1 [8];
  logic signed [tmva_pkg::DOT_W-1:0]  lvl2 [4];
  logic signed [tmva_pkg::DOT_W-1:0]  lvl3 [2];
  logic signed [tmva_pkg::DOT_W-1:0]  dot, dot_add;
  logic signed [tmva_pkg::ACC_W-1:0]  acc_q, acc_sum;
  logic signed [CMP_W-1:0]            acc_ext;
  logic signed [tmva_pkg::SUM_W-1:0]  sat_sum;
  logic                               res_push;

  logic signed [tmva_pkg::SUM_W-1:0]   res_sum_q [tmva_pkg::RESQ_DEPTH];
  logic                                res_ovf_q [tmva_pkg::RESQ_DEPTH];
  logic [tmva_pkg::RESQ_PTR_W-1:0]     res_wr_q, res_rd_q;
  logic [tmva_pkg::RESQ_CNT_W-1:0]     res_cnt_q;
  logic                                res_pop;

  // A request leaves the queue only when the result queue can take whatever
  // is already in the accumulate stage plus this one.
  assign credit_ok = ((res_cnt_q + tmva_pkg::RESQ_CNT_W'(s2_valid_q & s2_last_q)) <
                      tmva_pkg::RESQ_CNT_W'(tmva_pkg::RESQ_DEPTH));
  assign issue     = ~q_empty_i & credit_ok;
  assign q_pop_o   = issue;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (cmd_i.kind == tmva_pkg::KIND_LOAD) begin
        if (cmd_i.wr_en) begin
          mem_q[cmd_i.row][cmd_i.lane] <= cmd_i.value;
        end
      end else begin
        rd_q <= mem_q[cmd_i.row];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_word_q <= cmd_i.word;
      s2_skip_q <= cmd_i.skip;
      s2_last_q <= cmd_i.last;
      s2_ovf_q  <= cmd_i.ovf;
    end
  end

  always_comb begin
    for (int i = 0; i < tmva_pkg::CODES_PER_WORD; i++) begin
      case (tmva_pkg::code_e'(s2_word_q[i*tmva_pkg::CODE_W +: tmva_pkg::CODE_W]))
        tmva_pkg::CODE_NEG:  prod[i] = -(tmva_pkg::PROD_W'($signed(rd_q[i])));
        tmva_pkg::CODE_ZERO: prod[i] = '0;
        tmva_pkg::CODE_POS:  prod[i] = tmva_pkg::PROD_W'($signed(rd_q[i]));
        tmva_pkg::CODE_TWO:  prod[i] = tmva_pkg::PROD_W'($signed(rd_q[i])) <<< 1;
        default:             prod[i] = '0;
      endcase
    end
    for (int j = 0; j < 8; j++) begin
      lvl1[j] = tmva_pkg::DOT_W'(prod[2*j]) + tmva_pkg::DOT_W'(prod[2*j+1]);
    end
    for (int j = 0; j < 4; j++) begin
      lvl2[j] = lvl1[2*j] + lvl1[2*j+1];
    end
    for (int j = 0; j < 2; j++) begin
      lvl3[j] = lvl2[2*j] + lvl2[2*j+1];
    end
    dot     = lvl3[0] + lvl3[1];
    dot_add = s2_skip_q ? '0 : dot;
    acc_sum = acc_q + tmva_pkg::ACC_W'(dot_add);
    acc_ext = CMP_W'(acc_sum);
    if (acc_ext > SAT_HI) begin
      sat_sum = tmva_pkg::SUM_W'(SAT_HI);
    end else if (acc_ext < SAT_LO) begin
      sat_sum = tmva_pkg::SUM_W'(SAT_LO);
    end else begin
      sat_sum = tmva_pkg::SUM_W'(acc_ext);
    end
  end

  assign res_push = s2_valid_q & s2_last_q;
  assign res_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      acc_q      <= '0;
      res_wr_q   <= '0;
      res_rd_q   <= '0;
      res_cnt_q  <= '0;
    end else begin
      s2_valid_q <= issue & (cmd_i.kind == tmva_pkg::KIND_WEIGHT);
      if (s2_valid_q) begin
        acc_q <= s2_last_q ? '0 : acc_sum;
      end
      if (res_push) begin
        res_wr_q <= res_wr_q + 1'b1;
      end
      if (res_pop) begin
        res_rd_q <= res_rd_q + 1'b1;
      end
      res_cnt_q <= res_cnt_q + tmva_pkg::RESQ_CNT_W'(res_push)
                             - tmva_pkg::RESQ_CNT_W'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_sum_q[res_wr_q] <= sat_sum;
      res_ovf_q[res_wr_q] <= s2_ovf_q;
    end
  end

  assign empty_o        = (res_cnt_q == '0);
  assign row_sum_o      = res_sum_q[res_rd_q];
  assign row_overflow_o = res_ovf_q[res_rd_q];

endmodule

### sv/tmva_checker.sv
module tmva_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic signed [tmva_pkg::SUM_W-1:0]  row_sum_o,
  input logic                               row_overflow_o
);

  // During reset nothing is queued on either side.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not empty during reset");

  // A waiting result that is not taken stays as it is.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(row_sum_o) && $stable(row_overflow_o))
    else $error("waiting result changed before it was taken");

  // No row can exceed the largest positive sum of a full store.
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> row_sum_o <= 20'sd520192)
    else $error("row sum beyond reachable range");

  // With nothing waiting and nothing taken in for long enough to drain the
  // command queue, no result can appear at once.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && !push && $past(empty) && !$past(push) && $past(empty, 2) &&
    !$past(push, 2) && $past(empty, 3) && !$past(push, 3) &&
    $past(empty, 4) && !$past(push, 4) && $past(empty, 5) && !$past(push, 5) &&
    !full && !$past(full)
    |=> empty)
    else $error("result appeared without a request");

endmodule

bind ternary_matrix_vector_accumulate tmva_checker u_tmva_checker (.*);
